// ----- rtl/keyboard_controller_port_logic_defines.svh -----
// Assertion macros used by the checker file.
`ifndef KEYBOARD_CONTROLLER_PORT_LOGIC_DEFINES_SVH
`define KEYBOARD_CONTROLLER_PORT_LOGIC_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define KCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define KCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kcp_pkg.sv -----
`default_nettype none

package kcp_pkg;

  // Default number of internal RAM bytes.
  localparam int RAM_BYTES_DEF = 32;

  // Access kinds.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Port addresses.
  localparam logic [15:0] PORT_DATA = 16'h0060;
  localparam logic [15:0] PORT_CMD  = 16'h0064;

  // Command codes.
  localparam logic [7:0] CMD_READ_RAM_LO  = 8'h20;
  localparam logic [7:0] CMD_READ_RAM_HI  = 8'h3F;
  localparam logic [7:0] CMD_WRITE_RAM_LO = 8'h60;
  localparam logic [7:0] CMD_WRITE_RAM_HI = 8'h7F;
  localparam logic [7:0] CMD_DIS_SECOND   = 8'hA7;
  localparam logic [7:0] CMD_EN_SECOND    = 8'hA8;
  localparam logic [7:0] CMD_DIS_FIRST    = 8'hAD;
  localparam logic [7:0] CMD_EN_FIRST     = 8'hAE;
  localparam logic [7:0] CMD_WRITE_OUTPORT = 8'hD1;
  localparam logic [7:0] CMD_FAKE_FIRST   = 8'hD2;
  localparam logic [7:0] CMD_FAKE_SECOND  = 8'hD3;
  localparam logic [7:0] CMD_TO_SECOND    = 8'hD4;

  // Config byte bits and output port bit.
  localparam int CFG_FIRST_OFF_BIT  = 4;
  localparam int CFG_SECOND_OFF_BIT = 5;
  localparam int OUTPORT_A20_BIT    = 1;

  // Status byte bits.
  localparam int STAT_OUT_FULL_BIT = 0;
  localparam int STAT_LAST_CMD_BIT = 3;
  localparam int STAT_PENDING_BIT  = 6;

  // Forward kinds.
  localparam logic [1:0] FWD_NONE        = 2'd0;
  localparam logic [1:0] FWD_FAKE_FIRST  = 2'd1;
  localparam logic [1:0] FWD_FAKE_SECOND = 2'd2;
  localparam logic [1:0] FWD_TO_SECOND   = 2'd3;

  // Byte returned for an unknown port.
  localparam logic [7:0] BAD_PORT_BYTE = 8'hFF;

  typedef struct packed {
    logic        command;
    logic [15:0] port_address;
    logic [7:0]  write_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       bad_port;
    logic [1:0] forward_kind;
    logic [7:0] forward_byte;
    logic       a20_enabled;
    logic       overrun;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/kcp_in_stage.sv -----
`default_nettype none

module kcp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire kcp_pkg::in_t  in_data,
  input  wire logic          advance,
  output logic               stage_valid,
  output kcp_pkg::in_t       stage_data
);

  logic         stage_valid_r;
  logic         stage_valid_nxt;
  kcp_pkg::in_t stage_data_r;
  logic         in_fire;

  // The register takes a new beat whenever it is empty or drains this cycle.
  assign in_ready        = !stage_valid_r || advance;
  assign in_fire         = in_valid && in_ready;
  assign stage_valid_nxt = in_fire || (stage_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_data_r <= in_data;
    end
  end

  assign stage_valid = stage_valid_r;
  assign stage_data  = stage_data_r;

endmodule

`default_nettype wire

// ----- rtl/kcp_engine.sv -----
`default_nettype none

module kcp_engine #(
  parameter int RAM_BYTES = kcp_pkg::RAM_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fire,
  input  wire kcp_pkg::in_t item,
  output kcp_pkg::out_t     result
);

  localparam int RamAw = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
  localparam logic [5:0] RamDepth = 6'(RAM_BYTES);

  // Controller state.
  logic [7:0] out_buffer_r, out_buffer_nxt;
  logic       out_full_r, out_full_nxt;
  logic       last_cmd_r, last_cmd_nxt;
  logic       pending_r, pending_nxt;
  logic [7:0] pending_code_r, pending_code_nxt;
  logic       gate_a20_r, gate_a20_nxt;
  logic [7:0] ram_r [RAM_BYTES];

  // RAM write port and read path.
  logic             ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [4:0]       rd_idx;
  logic [4:0]       wr_idx;
  logic [7:0]       ram_rdata;
  logic [7:0]       v;

  assign v      = item.write_byte;
  assign rd_idx = v[4:0];
  assign wr_idx = pending_code_r[4:0];

  // Indexes past the configured size read as zero.
  assign ram_rdata = ({1'b0, rd_idx} < RamDepth) ? ram_r[rd_idx[RamAw-1:0]] : 8'h00;

  // Decode one access and work out the next state and the result beat.
  always_comb begin
    out_buffer_nxt   = out_buffer_r;
    out_full_nxt     = out_full_r;
    last_cmd_nxt     = last_cmd_r;
    pending_nxt      = pending_r;
    pending_code_nxt = pending_code_r;
    gate_a20_nxt     = gate_a20_r;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = ram_r[0];
    result           = '0;

    if (item.command == kcp_pkg::ACC_READ) begin
      if (item.port_address == kcp_pkg::PORT_DATA) begin
        out_full_nxt     = 1'b0;
        result.read_byte = out_buffer_r;
      end else if (item.port_address == kcp_pkg::PORT_CMD) begin
        result.read_byte[kcp_pkg::STAT_OUT_FULL_BIT] = out_full_r;
        result.read_byte[kcp_pkg::STAT_LAST_CMD_BIT] = last_cmd_r;
        result.read_byte[kcp_pkg::STAT_PENDING_BIT]  = pending_r;
      end else begin
        result.read_byte = kcp_pkg::BAD_PORT_BYTE;
        result.bad_port  = 1'b1;
      end
    end else if (item.port_address == kcp_pkg::PORT_DATA) begin
      // Data byte: completes a pending two-byte command, else only clears the last-command flag.
      last_cmd_nxt = 1'b0;
      if (pending_r) begin
        pending_nxt = 1'b0;
        case (pending_code_r)
          kcp_pkg::CMD_WRITE_OUTPORT: begin
            gate_a20_nxt = v[kcp_pkg::OUTPORT_A20_BIT];
          end
          kcp_pkg::CMD_FAKE_FIRST: begin
            result.forward_kind = kcp_pkg::FWD_FAKE_FIRST;
            result.forward_byte = v;
          end
          kcp_pkg::CMD_FAKE_SECOND: begin
            result.forward_kind = kcp_pkg::FWD_FAKE_SECOND;
            result.forward_byte = v;
          end
          kcp_pkg::CMD_TO_SECOND: begin
            result.forward_kind = kcp_pkg::FWD_TO_SECOND;
            result.forward_byte = v;
          end
          default: begin
            if (pending_code_r inside {[kcp_pkg::CMD_WRITE_RAM_LO:kcp_pkg::CMD_WRITE_RAM_HI]}
                && ({1'b0, wr_idx} < RamDepth)) begin
              ram_we    = 1'b1;
              ram_waddr = wr_idx[RamAw-1:0];
              ram_wdata = v;
            end
          end
        endcase
      end
    end else if (item.port_address == kcp_pkg::PORT_CMD) begin
      // Command byte: a pending command is cancelled and the byte dropped; otherwise the byte is decoded.
      last_cmd_nxt = 1'b1;
      if (pending_r) begin
        pending_nxt = 1'b0;
      end else begin
        case (v)
          kcp_pkg::CMD_DIS_SECOND: begin
            ram_we = 1'b1;
            ram_wdata[kcp_pkg::CFG_SECOND_OFF_BIT] = 1'b1;
          end
          kcp_pkg::CMD_EN_SECOND: begin
            ram_we = 1'b1;
            ram_wdata[kcp_pkg::CFG_SECOND_OFF_BIT] = 1'b0;
          end
          kcp_pkg::CMD_DIS_FIRST: begin
            ram_we = 1'b1;
            ram_wdata[kcp_pkg::CFG_FIRST_OFF_BIT] = 1'b1;
          end
          kcp_pkg::CMD_EN_FIRST: begin
            ram_we = 1'b1;
            ram_wdata[kcp_pkg::CFG_FIRST_OFF_BIT] = 1'b0;
          end
          default: begin
            if (v inside {[kcp_pkg::CMD_READ_RAM_LO:kcp_pkg::CMD_READ_RAM_HI]}) begin
              if (out_full_r) begin
                result.overrun = 1'b1;
              end else begin
                out_buffer_nxt = ram_rdata;
                out_full_nxt   = 1'b1;
              end
            end else begin
              pending_code_nxt = v;
              pending_nxt      = 1'b1;
            end
          end
        endcase
      end
    end

    result.a20_enabled = gate_a20_nxt;
  end

  // State registers; the RAM is small enough to clear directly at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_buffer_r   <= 8'h00;
      out_full_r     <= 1'b0;
      last_cmd_r     <= 1'b0;
      pending_r      <= 1'b0;
      pending_code_r <= 8'h00;
      gate_a20_r     <= 1'b0;
      for (int i = 0; i < RAM_BYTES; i++) begin
        ram_r[i] <= 8'h00;
      end
    end else if (fire) begin
      out_buffer_r   <= out_buffer_nxt;
      out_full_r     <= out_full_nxt;
      last_cmd_r     <= last_cmd_nxt;
      pending_r      <= pending_nxt;
      pending_code_r <= pending_code_nxt;
      gate_a20_r     <= gate_a20_nxt;
      if (ram_we) begin
        ram_r[ram_waddr] <= ram_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kcp_out_stage.sv -----
`default_nettype none

module kcp_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          stage_valid,
  input  wire kcp_pkg::out_t result,
  output logic               advance,
  output logic               fire,
  output logic               out_valid,
  input  wire logic          out_ready,
  output kcp_pkg::out_t      out_data
);

  logic          out_valid_r;
  logic          out_valid_nxt;
  kcp_pkg::out_t out_data_r;

  // The result register loads when empty or when its beat leaves this cycle.
  assign advance       = !out_valid_r || out_ready;
  assign fire          = stage_valid && advance;
  assign out_valid_nxt = fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/keyboard_controller_port_logic.sv -----
// 8042-style keyboard controller port logic. Each input beat is one bus access (read or
// write at a 16-bit port address; 0x60 data, 0x64 status/command) and yields exactly one
// result beat. The block takes one access per clock cycle when the result side keeps up;
// each access passes through the input register and then the result register, with
// the decode and all state updates in the single logic pass between them. The internal
// RAM is held in flip-flops and cleared by reset at once, so no clearing pass follows reset.
`default_nettype none

module keyboard_controller_port_logic #(
  parameter int RAM_BYTES = kcp_pkg::RAM_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire kcp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output kcp_pkg::out_t      out_data
);

  logic          advance;
  logic          fire;
  logic          stage_valid;
  kcp_pkg::in_t  stage_data;
  kcp_pkg::out_t result;

  kcp_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  kcp_engine #(
    .RAM_BYTES (RAM_BYTES)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (stage_data),
    .result (result)
  );

  kcp_out_stage u_out_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .result      (result),
    .advance     (advance),
    .fire        (fire),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/kcp_checker.sv -----
`default_nettype none
`include "keyboard_controller_port_logic_defines.svh"

module kcp_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire kcp_pkg::out_t out_data
);

  // An unknown-port read returns the fill byte.
  `KCP_ASSERT_NOW(a_bad_port_byte, out_valid && out_data.bad_port, out_data.read_byte == kcp_pkg::BAD_PORT_BYTE, "bad port read without fill byte")

  // An unknown-port read never forwards to a device or reports an overrun.
  `KCP_ASSERT_NOW(a_bad_port_quiet, out_valid && out_data.bad_port, (out_data.forward_kind == kcp_pkg::FWD_NONE) && !out_data.overrun, "bad port read with side effect")

  // No forwarded byte unless a device is selected.
  `KCP_ASSERT_NOW(a_fwd_byte_zero, out_valid && (out_data.forward_kind == kcp_pkg::FWD_NONE), out_data.forward_byte == 8'h00, "forward byte without device")

  // A stalled result beat holds.
  `KCP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

endmodule

bind keyboard_controller_port_logic kcp_checker u_kcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
